[rtl/core/tvr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvr_pkg
// Shared widths, reset values, register indexes and types of the trajectory
// velocity retimer.
// ----------------------------------------------------------------------------
package tvr_pkg;

    localparam int ANGLE_W      = 32;
    localparam int STAMP_W      = 32;
    localparam int DELTA_W      = ANGLE_W + 1;
    localparam int ANGLE_FIELDS = 7;
    localparam int FRAC_W       = 16;
    localparam int LIMIT_W      = 23;
    localparam int INV_W        = 25;
    localparam int TPROD_W      = DELTA_W + INV_W;
    localparam int LPROD_W      = LIMIT_W + STAMP_W;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = STAMP_W + ANGLE_FIELDS * ANGLE_W;
    localparam int M_TUSER_W    = 2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [FRAC_W-1:0]  ROUND_HALF = FRAC_W'(1 << (FRAC_W - 1));

    localparam logic [LIMIT_W-1:0] LARGE_LIMIT_RST = 23'd49414;
    localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RST = 23'd61768;
    localparam logic [INV_W-1:0]   LARGE_INV_RST   = 25'd86916;
    localparam logic [INV_W-1:0]   SMALL_INV_RST   = 25'd69534;

    localparam logic [CFG_INDEX_W-1:0] CFG_LARGE_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_LIMIT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LARGE_INV   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_INV   = 8'd3;

    // segment header classified by the front part
    typedef struct packed {
        logic               first;
        logic               time_ok;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] planned;
    } t_seg_hdr;

    localparam int HDR_W = $bits(t_seg_hdr);

    typedef struct packed {
        logic [LIMIT_W-1:0] large_limit;
        logic [LIMIT_W-1:0] small_limit;
        logic [INV_W-1:0]   large_inv;
        logic [INV_W-1:0]   small_inv;
    } t_cfg;

endpackage

[rtl/core/tvr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvr_front
// Keeps the previous point and turns each new point into a segment: planned
// time, time check and absolute per-joint travel.
// ----------------------------------------------------------------------------
module tvr_front
    import tvr_pkg::*;
#(
    parameter int JOINTS = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_first,
    input  logic [STAMP_W-1:0]        i_stamp,
    input  logic signed [ANGLE_W-1:0] i_angles [ANGLE_FIELDS],
    output t_seg_hdr                  o_hdr,
    output logic [DELTA_W-1:0]        o_deltas [JOINTS]
);

    logic signed [ANGLE_W-1:0] r_last [JOINTS];
    logic [STAMP_W-1:0]        r_last_stamp;
    logic signed [ANGLE_W-1:0] w_cur  [JOINTS];
    logic signed [DELTA_W-1:0] w_diff [JOINTS];
    logic                      w_time_ok;

    for (genvar j = 0; j < JOINTS; j++) begin : g_joint
        if (j < ANGLE_FIELDS) begin : g_field
            assign w_cur[j] = i_angles[j];
        end else begin : g_zero
            // joints with no field sit at position zero
            assign w_cur[j] = '0;
        end
        assign w_diff[j]   = {w_cur[j][ANGLE_W-1], w_cur[j]}
                           - {r_last[j][ANGLE_W-1], r_last[j]};
        assign o_deltas[j] = w_diff[j][DELTA_W-1] ? DELTA_W'(-w_diff[j]) : w_diff[j];
    end

    assign w_time_ok       = i_stamp > r_last_stamp;
    assign o_hdr.first     = i_first;
    assign o_hdr.time_ok   = w_time_ok;
    assign o_hdr.stamp     = i_stamp;
    assign o_hdr.planned   = w_time_ok ? (i_stamp - r_last_stamp) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINTS; j++) begin
                r_last[j] <= '0;
            end
            r_last_stamp <= '0;
        end else if (i_accept) begin
            for (int j = 0; j < JOINTS; j++) begin
                r_last[j] <= w_cur[j];
            end
            r_last_stamp <= i_stamp;
        end
    end

endmodule

[rtl/core/tvr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvr_queue
// Short register queue between the front and the back part.
// ----------------------------------------------------------------------------
module tvr_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [DATA_W-1:0]                i_data,
    output logic                             o_ready,
    input  logic                             i_pop,
    output logic                             o_valid,
    output logic [DATA_W-1:0]                o_data,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = r_count != COUNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/tvr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvr_back
// Execution pipeline: per-joint products, speed test and travel time,
// maximum over joints, running correction and the output register.
// ----------------------------------------------------------------------------
module tvr_back
    import tvr_pkg::*;
#(
    parameter int JOINTS       = 7,
    parameter int LARGE_JOINTS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  t_seg_hdr           i_hdr,
    input  logic [DELTA_W-1:0] i_deltas [JOINTS],
    input  t_cfg               i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [STAMP_W-1:0] o_stamp,
    output logic               o_invalid,
    output logic               o_saturated
);

    localparam int HALF    = (JOINTS + 1) / 2;
    localparam int ROUND_W = TPROD_W + 1;
    localparam int SHIFT_W = ROUND_W - FRAC_W;

    typedef struct packed {
        logic               first;
        logic               invalid;
        logic [STAMP_W-1:0] stamp;
    } t_meta;

    logic w_en;

    // multiply stage
    logic               r_m_valid;
    t_seg_hdr           r_m_hdr;
    logic [DELTA_W-1:0] r_m_delta [JOINTS];
    logic [TPROD_W-1:0] r_m_tprod [JOINTS];
    logic [LPROD_W-1:0] r_m_lprod_large;
    logic [LPROD_W-1:0] r_m_lprod_small;
    logic [INV_W-1:0]   w_inv [JOINTS];

    // travel time stage
    logic               r_t_valid;
    t_meta              r_t_meta;
    logic [STAMP_W-1:0] r_t_time [JOINTS];
    logic [STAMP_W-1:0] w_time [JOINTS];
    logic [JOINTS-1:0]  w_fast;
    t_meta              w_t_meta;

    // pair maximum stage
    logic               r_p_valid;
    t_meta              r_p_meta;
    logic [STAMP_W-1:0] r_p_max [HALF];
    logic [STAMP_W-1:0] w_pair [HALF];

    // joint maximum stage
    logic               r_x_valid;
    t_meta              r_x_meta;
    logic [STAMP_W-1:0] r_x_max;
    logic [STAMP_W-1:0] w_xmax;

    // correction stage
    logic               r_c_valid;
    t_meta              r_c_meta;
    logic [STAMP_W-1:0] r_tc;
    logic [STAMP_W:0]   w_tc_sum;
    logic [STAMP_W-1:0] n_tc;

    // output register
    logic               r_out_valid;
    logic [STAMP_W-1:0] r_out_stamp;
    logic               r_out_invalid;
    logic               r_out_saturated;
    logic [STAMP_W:0]   w_out_sum;
    logic [STAMP_W-1:0] w_corrected;

    assign w_en  = !r_out_valid || i_ready;
    assign o_pop = w_en && i_valid;

    for (genvar j = 0; j < JOINTS; j++) begin : g_joint
        localparam bit IS_LARGE = j < LARGE_JOINTS;
        logic [ROUND_W-1:0] w_round;
        logic [SHIFT_W-1:0] w_shift;
        logic [LPROD_W-1:0] w_lim;

        assign w_inv[j] = IS_LARGE ? i_cfg.large_inv : i_cfg.small_inv;
        assign w_round  = ROUND_W'(r_m_tprod[j]) + ROUND_W'(ROUND_HALF);
        assign w_shift  = w_round[ROUND_W-1:FRAC_W];
        assign w_time[j] = (|w_shift[SHIFT_W-1:STAMP_W]) ? STAMP_MAX
                                                         : w_shift[STAMP_W-1:0];
        assign w_lim     = IS_LARGE ? r_m_lprod_large : r_m_lprod_small;
        // too fast when delta * 2^16 exceeds limit * planned
        assign w_fast[j] = r_m_hdr.time_ok
                        && (LPROD_W'({r_m_delta[j], FRAC_W'(0)}) > w_lim);
    end

    assign w_t_meta.first   = r_m_hdr.first;
    assign w_t_meta.invalid = !r_m_hdr.first && (!r_m_hdr.time_ok || (|w_fast));
    assign w_t_meta.stamp   = r_m_hdr.stamp;

    for (genvar k = 0; k < HALF; k++) begin : g_pair
        if (2 * k + 1 < JOINTS) begin : g_two
            assign w_pair[k] = (r_t_time[2*k] > r_t_time[2*k+1]) ? r_t_time[2*k]
                                                                 : r_t_time[2*k+1];
        end else begin : g_one
            assign w_pair[k] = r_t_time[2*k];
        end
    end

    always_comb begin
        w_xmax = r_p_max[0];
        for (int k = 1; k < HALF; k++) begin
            if (r_p_max[k] > w_xmax) begin
                w_xmax = r_p_max[k];
            end
        end
    end

    assign w_tc_sum = {1'b0, r_tc} + {1'b0, r_x_max};

    always_comb begin
        n_tc = r_tc;
        if (r_x_meta.first) begin
            n_tc = '0;
        end else if (r_x_meta.invalid) begin
            n_tc = w_tc_sum[STAMP_W] ? STAMP_MAX : w_tc_sum[STAMP_W-1:0];
        end
    end

    assign w_out_sum   = {1'b0, r_c_meta.stamp} + {1'b0, r_tc};
    assign w_corrected = w_out_sum[STAMP_W] ? STAMP_MAX : w_out_sum[STAMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_t_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_x_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_tc        <= '0;
        end else if (w_en) begin
            r_m_valid   <= i_valid;
            r_t_valid   <= r_m_valid;
            r_p_valid   <= r_t_valid;
            r_x_valid   <= r_p_valid;
            r_c_valid   <= r_x_valid;
            r_out_valid <= r_c_valid;
            if (r_x_valid) begin
                r_tc <= n_tc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_hdr         <= i_hdr;
            r_m_lprod_large <= LPROD_W'(i_cfg.large_limit) * LPROD_W'(i_hdr.planned);
            r_m_lprod_small <= LPROD_W'(i_cfg.small_limit) * LPROD_W'(i_hdr.planned);
            for (int j = 0; j < JOINTS; j++) begin
                r_m_delta[j] <= i_deltas[j];
                r_m_tprod[j] <= TPROD_W'(i_deltas[j]) * TPROD_W'(w_inv[j]);
                r_t_time[j]  <= w_time[j];
            end
            r_t_meta <= w_t_meta;
            r_p_meta <= r_t_meta;
            for (int k = 0; k < HALF; k++) begin
                r_p_max[k] <= w_pair[k];
            end
            r_x_meta        <= r_p_meta;
            r_x_max         <= w_xmax;
            r_c_meta        <= r_x_meta;
            r_out_stamp     <= w_corrected;
            r_out_invalid   <= r_c_meta.invalid;
            r_out_saturated <= (w_corrected == STAMP_MAX) || (r_tc == STAMP_MAX);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_stamp     = r_out_stamp;
    assign o_invalid   = r_out_invalid;
    assign o_saturated = r_out_saturated;

endmodule

[rtl/core/trajectory_velocity_retimer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_velocity_retimer
// Checks trajectory segments against joint speed limits and retimes stamps.
// ----------------------------------------------------------------------------
// usage
//  - slave stream: one beat per trajectory point; tdata holds the stamp and
//    the seven joint angles, tuser[0] marks the first point of a trajectory
//  - master stream: one beat per point; tdata is the corrected stamp,
//    tuser carries the invalid-segment and saturation flags
//  - config channel: index/data writes of the two speed limits and their
//    reciprocals; always ready, write only while the block is idle
//  - throughput: one point per cycle, sustained while the receiver is ready;
//    every stage of the back pipeline holds one point and the running correction is a single add
//  - path: the queue, then the product, travel time, pair max, joint max,
//    correction and output register stages, in that order, up to tvalid
//  - reset: previous point and correction clear to zero, registers take
//    their default limits, queue and pipeline empty
//  - receiver stall: the back pipeline freezes, the queue between front and
//    back keeps taking points until full, then tready drops
// ----------------------------------------------------------------------------
module trajectory_velocity_retimer
    import tvr_pkg::*;
#(
    parameter int JOINTS       = 7,
    parameter int LARGE_JOINTS = 4,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // stamp[31:0], angle_a[63:32] .. angle_g[255:224]
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    // first_point[0]
    input  logic [0:0]             i_s_axis_tuser,
    // master stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // corrected_stamp[31:0]
    output logic [STAMP_W-1:0]     o_m_axis_tdata,
    // segment_invalid[0], saturated[1]
    output logic [M_TUSER_W-1:0]   o_m_axis_tuser,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int Q_DATA_W  = HDR_W + JOINTS * DELTA_W;
    localparam int Q_COUNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg                      r_cfg;
    logic signed [ANGLE_W-1:0] w_angles [ANGLE_FIELDS];
    logic                      w_s_accept;
    t_seg_hdr                  w_f_hdr;
    logic [DELTA_W-1:0]        w_f_deltas [JOINTS];
    logic [Q_DATA_W-1:0]       w_q_wdata;
    logic [Q_DATA_W-1:0]       w_q_rdata;
    logic                      w_q_valid;
    logic                      w_q_pop;
    logic [Q_COUNT_W-1:0]      w_q_count;
    t_seg_hdr                  w_b_hdr;
    logic [DELTA_W-1:0]        w_b_deltas [JOINTS];

    // config registers, low bits of each write kept
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.large_limit <= LARGE_LIMIT_RST;
            r_cfg.small_limit <= SMALL_LIMIT_RST;
            r_cfg.large_inv   <= LARGE_INV_RST;
            r_cfg.small_inv   <= SMALL_INV_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LARGE_LIMIT: r_cfg.large_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_SMALL_LIMIT: r_cfg.small_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_LARGE_INV:   r_cfg.large_inv   <= i_cfg_data[INV_W-1:0];
                CFG_SMALL_INV:   r_cfg.small_inv   <= i_cfg_data[INV_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // unpack the angle fields of the input beat
    for (genvar a = 0; a < ANGLE_FIELDS; a++) begin : g_angle
        assign w_angles[a] = i_s_axis_tdata[STAMP_W + a*ANGLE_W +: ANGLE_W];
    end

    assign w_s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // front: previous point and segment classification
    tvr_front #(
        .JOINTS (JOINTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_s_accept),
        .i_first  (i_s_axis_tuser[0]),
        .i_stamp  (i_s_axis_tdata[STAMP_W-1:0]),
        .i_angles (w_angles),
        .o_hdr    (w_f_hdr),
        .o_deltas (w_f_deltas)
    );

    // queue entry: header in the low bits, joint travel above
    assign w_q_wdata[HDR_W-1:0] = w_f_hdr;
    assign w_b_hdr              = w_q_rdata[HDR_W-1:0];
    for (genvar j = 0; j < JOINTS; j++) begin : g_pack
        assign w_q_wdata[HDR_W + j*DELTA_W +: DELTA_W] = w_f_deltas[j];
        assign w_b_deltas[j] = w_q_rdata[HDR_W + j*DELTA_W +: DELTA_W];
    end

    tvr_queue #(
        .DATA_W (Q_DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_s_accept),
        .i_data  (w_q_wdata),
        .o_ready (o_s_axis_tready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata),
        .o_count (w_q_count)
    );

    // back: checks, travel time, correction and output register
    tvr_back #(
        .JOINTS       (JOINTS),
        .LARGE_JOINTS (LARGE_JOINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_pop       (w_q_pop),
        .i_hdr       (w_b_hdr),
        .i_deltas    (w_b_deltas),
        .i_cfg       (r_cfg),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_stamp     (o_m_axis_tdata),
        .o_invalid   (o_m_axis_tuser[0]),
        .o_saturated (o_m_axis_tuser[1])
    );

`ifndef ASSERT_OFF
    // a saturated stamp always raises the saturation flag
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata == STAMP_MAX)) |-> o_m_axis_tuser[1])
        else $error("saturated stamp without saturation flag");

    // queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= Q_COUNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a beat taken with no pop grows the queue by one
    a_q_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && !w_q_pop) |=> (w_q_count == $past(w_q_count) + 1'b1))
        else $error("queue count lost an accepted beat");
`endif

endmodule

[tb/sv/tvr_retime_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvr_retime_checker
// Watches the point stream, the retimed stream and the register writes of the
// trajectory velocity retimer, predicts every retimed beat and compares them
// in order.
// ----------------------------------------------------------------------------
module tvr_retime_checker
    import tvr_pkg::*;
#(
    parameter int JOINTS       = 7,
    parameter int LARGE_JOINTS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    input  logic [0:0]             i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [STAMP_W-1:0]     i_m_tdata,
    input  logic [M_TUSER_W-1:0]   i_m_tuser,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               invalid;
        logic               saturated;
    } t_retimed;

    t_cfg               limits;
    logic [ANGLE_W-1:0] prev_angle [JOINTS];
    logic [STAMP_W-1:0] prev_stamp;
    logic [STAMP_W-1:0] correction;
    t_retimed           retimed_q [$];

    // advances the segment state by one point and returns its retimed beat
    function automatic t_retimed retime_point(input logic first,
                                              input logic [S_TDATA_W-1:0] beat);
        t_retimed                  r;
        logic [STAMP_W-1:0]        stamp;
        logic [ANGLE_W-1:0]        now_angle [JOINTS];
        logic signed [DELTA_W-1:0] diff;
        logic [63:0]               planned, delta, travel, slowest, lim, inv, acc;
        logic                      time_ok, bad;
        stamp = beat[STAMP_W-1:0];
        for (int j = 0; j < JOINTS; j++) begin
            now_angle[j] = (j < ANGLE_FIELDS) ? beat[STAMP_W + j*ANGLE_W +: ANGLE_W] : '0;
        end
        bad = 1'b0;
        if (first) begin
            correction = '0;
        end else begin
            time_ok = stamp > prev_stamp;
            planned = time_ok ? 64'(stamp - prev_stamp) : 64'd0;
            bad     = !time_ok;
            slowest = '0;
            for (int j = 0; j < JOINTS; j++) begin
                diff = $signed({now_angle[j][ANGLE_W-1], now_angle[j]})
                     - $signed({prev_angle[j][ANGLE_W-1], prev_angle[j]});
                if (diff < 0) begin
                    delta = 64'(-diff);
                end else begin
                    delta = 64'(diff);
                end
                lim = (j < LARGE_JOINTS) ? 64'(limits.large_limit) : 64'(limits.small_limit);
                inv = (j < LARGE_JOINTS) ? 64'(limits.large_inv) : 64'(limits.small_inv);
                // travel time rounded to nearest, ties up
                travel = (delta * inv + 64'(ROUND_HALF)) >> FRAC_W;
                if (travel > 64'(STAMP_MAX)) begin
                    travel = 64'(STAMP_MAX);
                end
                // exact speed test without a division
                if (time_ok && (delta << FRAC_W) > lim * planned) begin
                    bad = 1'b1;
                end
                if (travel > slowest) begin
                    slowest = travel;
                end
            end
            if (bad) begin
                acc        = 64'(correction) + slowest;
                correction = (acc > 64'(STAMP_MAX)) ? STAMP_MAX : acc[STAMP_W-1:0];
            end
        end
        acc         = 64'(stamp) + 64'(correction);
        r.stamp     = (acc > 64'(STAMP_MAX)) ? STAMP_MAX : acc[STAMP_W-1:0];
        r.invalid   = bad;
        r.saturated = (r.stamp == STAMP_MAX) || (correction == STAMP_MAX);
        prev_angle  = now_angle;
        prev_stamp  = stamp;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_retimed want;
        if (!i_rst_n) begin
            limits.large_limit = LARGE_LIMIT_RST;
            limits.small_limit = SMALL_LIMIT_RST;
            limits.large_inv   = LARGE_INV_RST;
            limits.small_inv   = SMALL_INV_RST;
            prev_angle         = '{default: '0};
            prev_stamp         = '0;
            correction         = '0;
            retimed_q.delete();
            o_fail_count       = 0;
            o_pending          = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LARGE_LIMIT: limits.large_limit = i_cfg_data[LIMIT_W-1:0];
                    CFG_SMALL_LIMIT: limits.small_limit = i_cfg_data[LIMIT_W-1:0];
                    CFG_LARGE_INV:   limits.large_inv   = i_cfg_data[INV_W-1:0];
                    CFG_SMALL_INV:   limits.small_inv   = i_cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (retimed_q.size() == 0) begin
                    $error("corrected_stamp: expected none, actual %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = retimed_q.pop_front();
                    if (i_m_tdata !== want.stamp) begin
                        $error("corrected_stamp: expected %h, actual %h", want.stamp, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tuser[0] !== want.invalid) begin
                        $error("segment_invalid: expected %b, actual %b",
                               want.invalid, i_m_tuser[0]);
                        o_fail_count++;
                    end
                    if (i_m_tuser[1] !== want.saturated) begin
                        $error("saturated: expected %b, actual %b", want.saturated, i_m_tuser[1]);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                retimed_q.insert(retimed_q.size(), retime_point(i_s_tuser[0], i_s_tdata));
            end
            o_pending = retimed_q.size();
        end
    end

endmodule

[tb/sv/trajectory_velocity_retimer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_velocity_retimer_tb
// Feeds the retimer directed trajectory points (reset defaults, speed limit
// boundaries, non-advancing stamps, angle and stamp extremes, correction
// saturation, rounding ties) and then random trajectories under several
// register settings, with random stalls on both streams. A checker beside the
// block predicts every retimed beat; this module only drives and judges.
// ----------------------------------------------------------------------------
module trajectory_velocity_retimer_tb;
    import tvr_pkg::*;

    localparam int JOINTS       = 7;
    localparam int LARGE_JOINTS = 4;
    localparam int IDLE_LIMIT   = 1000;  // cycles with no beat on any channel
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int TAIL_CYCLES  = 20;    // latency margin after the last result
    localparam int PHASE_POINTS = 230;
    localparam int PHASES       = 5;

    localparam logic [STAMP_W-1:0]     ONE_SEC     = 32'h0001_0000;
    localparam logic [ANGLE_W-1:0]     ONE_RAD     = 32'h0001_0000;
    localparam logic [ANGLE_W-1:0]     ANGLE_MIN   = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0]     ANGLE_MAX   = 32'h7FFF_FFFF;
    localparam logic [CFG_DATA_W-1:0]  LIMIT_TOP   = 32'd4194304;
    localparam logic [CFG_DATA_W-1:0]  INV_TOP     = 32'd16777216;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRAY_TOP = '1;  // past the last register

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [STAMP_W-1:0]     m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending;

    // stall control shared by the sender and receiver processes
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit hold_rx     = 1'b0;
    int tx_gap_odds = 25;   // percent of points preceded by an idle burst
    int idle_cycles = 0;

    // limits as last written, used only to shape the random segments
    logic [LIMIT_W-1:0] shape_large = LARGE_LIMIT_RST;
    logic [LIMIT_W-1:0] shape_small = SMALL_LIMIT_RST;

    // last point sent and the next one being built
    logic [STAMP_W-1:0] trk_stamp = '0;
    logic [ANGLE_W-1:0] trk_angle [JOINTS] = '{default: '0};
    logic [ANGLE_W-1:0] nx_angle  [JOINTS] = '{default: '0};

    always #5 clk = ~clk;

    trajectory_velocity_retimer #(
        .JOINTS       (JOINTS),
        .LARGE_JOINTS (LARGE_JOINTS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    tvr_retime_checker #(
        .JOINTS       (JOINTS),
        .LARGE_JOINTS (LARGE_JOINTS)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: any beat on any channel restarts the count
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: ready runs and stall bursts, a long hold-off on request,
    // always ready in the calm tail
    initial begin
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end else if (rx_calm || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat (rx_calm ? 1 : $urandom_range(1, 30)) @(posedge clk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // one point beat from nx_angle, optionally after an idle burst
    task automatic send_point(input logic first, input logic [STAMP_W-1:0] stamp);
        int gap;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 99) < tx_gap_odds) begin
            gap = $urandom_range(1, 12);
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {nx_angle[6], nx_angle[5], nx_angle[4], nx_angle[3],
                     nx_angle[2], nx_angle[1], nx_angle[0], stamp};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        trk_stamp = stamp;
        trk_angle = nx_angle;
    endtask

    // stop offering and wait for every outstanding result; the first edge
    // lets the checker see a beat taken on the current one
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // one register beat, valid stays high for a following write
    task automatic put_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // writes all four limits, plus ignored indexes when asked; block idle
    task automatic load_limits(input logic [CFG_DATA_W-1:0] ll, input logic [CFG_DATA_W-1:0] sl,
                               input logic [CFG_DATA_W-1:0] li, input logic [CFG_DATA_W-1:0] si,
                               input bit stray);
        put_reg(CFG_LARGE_LIMIT, ll);
        put_reg(CFG_SMALL_LIMIT, sl);
        put_reg(CFG_LARGE_INV, li);
        put_reg(CFG_SMALL_INV, si);
        if (stray) begin
            put_reg(CFG_INDEX_W'($urandom_range(4, 255)), $urandom());
            put_reg(CFG_STRAY_TOP, $urandom());
        end
        cfg_valid   <= 1'b0;
        shape_large  = ll[LIMIT_W-1:0];
        shape_small  = sl[LIMIT_W-1:0];
    endtask

    // mostly well-formed trajectory segments sized against the limits,
    // some deliberately just or far too fast; the rest restarts, stamps that
    // do not advance, and pure noise
    task automatic random_point();
        int                 pick;
        int                 fast_joint;
        logic               first;
        logic [STAMP_W-1:0] stamp;
        logic [63:0]        dt, lim, allowed, step;
        pick     = $urandom_range(0, 99);
        first    = 1'b0;
        nx_angle = trk_angle;
        if (pick < 4) begin
            // new trajectory, now and then close to the end of time
            first = 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                stamp = STAMP_MAX - STAMP_W'($urandom_range(0, 1 << 20));
            end else begin
                stamp = STAMP_W'($urandom_range(0, 1 << 20));
            end
            for (int j = 0; j < JOINTS; j++) nx_angle[j] = $urandom();
        end else if (pick < 12) begin
            first = 1'($urandom_range(0, 1));
            stamp = $urandom();
            for (int j = 0; j < JOINTS; j++) nx_angle[j] = $urandom();
        end else if (pick < 20) begin
            // stamp equal to or behind the previous one
            stamp = trk_stamp - STAMP_W'($urandom_range(0, 4096));
            for (int j = 0; j < JOINTS; j++) begin
                nx_angle[j] = trk_angle[j] + ANGLE_W'($urandom_range(0, 1 << 18)) - (1 << 17);
            end
        end else begin
            dt = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(1, 16))
                                             : 64'($urandom_range(1, 1 << 17));
            stamp      = trk_stamp + dt[STAMP_W-1:0];
            fast_joint = ($urandom_range(0, 2) == 0) ? $urandom_range(0, JOINTS - 1) : JOINTS;
            for (int j = 0; j < JOINTS; j++) begin
                lim     = (j < LARGE_JOINTS) ? 64'(shape_large) : 64'(shape_small);
                allowed = (lim * dt) >> 16;
                if (allowed > 64'h3FFF_FFFF) begin
                    allowed = 64'h3FFF_FFFF;
                end
                if (j == fast_joint) begin
                    // one lsb over the limit, or well over it
                    step = allowed + (($urandom_range(0, 1) == 0) ? 64'd1
                           : 64'($urandom_range(1, 32'(allowed / 4) + 1)));
                end else if ($urandom_range(0, 3) == 0) begin
                    step = allowed;
                end else begin
                    step = 64'($urandom_range(0, 32'(allowed)));
                end
                if ($urandom_range(0, 1) == 0) begin
                    nx_angle[j] = trk_angle[j] + step[ANGLE_W-1:0];
                end else begin
                    nx_angle[j] = trk_angle[j] - step[ANGLE_W-1:0];
                end
            end
        end
        send_point(first, stamp);
    endtask

    // directed points, first under the reset limits
    task automatic directed_points();
        // first segment after reset, stamp not past the reset stamp
        nx_angle = '{default: '0};
        send_point(1'b0, '0);
        // slow segment, one large and one small joint moving
        nx_angle[0] = 32'h0000_8000;
        nx_angle[6] = 32'hFFFF_8000;
        send_point(1'b0, 2 * ONE_SEC);
        // large joint too fast
        nx_angle = trk_angle;
        nx_angle[1] = trk_angle[1] + 5 * ONE_RAD;
        send_point(1'b0, 3 * ONE_SEC);
        // small joint too fast
        nx_angle = trk_angle;
        nx_angle[5] = trk_angle[5] + 5 * ONE_RAD;
        send_point(1'b0, 4 * ONE_SEC);
        // stamp unchanged, no movement
        nx_angle = trk_angle;
        send_point(1'b0, 4 * ONE_SEC);
        // stamp going back with movement
        nx_angle[2] = trk_angle[2] + ONE_RAD;
        send_point(1'b0, 3 * ONE_SEC);
        // restart at the most negative angles, correction cleared
        nx_angle = '{default: ANGLE_MIN};
        send_point(1'b1, 100 * ONE_SEC);
        // full-scale swing on every joint, correction saturates
        nx_angle = '{default: ANGLE_MAX};
        send_point(1'b0, 101 * ONE_SEC);
        // still, at the last stamp
        send_point(1'b0, STAMP_MAX);
        // restart at the last stamp
        nx_angle = '{default: '1};
        send_point(1'b1, STAMP_MAX);
        // crossing zero by two lsb, stamp wraps back to zero
        nx_angle = '{default: 32'd1};
        send_point(1'b0, '0);
        nx_angle = '{default: '0};
        send_point(1'b1, '0);

        // zero limits, unit reciprocals: rounding ties and any movement too fast
        settle();
        load_limits('0, '0, 32'd1, 32'd1, 1'b0);
        nx_angle = trk_angle;
        nx_angle[0] = 32'h0000_8000;
        send_point(1'b0, ONE_SEC);
        nx_angle[0] = trk_angle[0] + 32'h0000_7FFF;
        send_point(1'b0, 2 * ONE_SEC);
        nx_angle = trk_angle;
        send_point(1'b0, 3 * ONE_SEC);

        // top limits and reciprocals: exactly at the limit, then one lsb over
        settle();
        load_limits(LIMIT_TOP, LIMIT_TOP, INV_TOP, INV_TOP, 1'b0);
        nx_angle = trk_angle;
        nx_angle[4] = trk_angle[4] + 64 * ONE_RAD;
        send_point(1'b0, 4 * ONE_SEC);
        nx_angle = trk_angle;
        nx_angle[4] = trk_angle[4] + 64 * ONE_RAD + 1;
        send_point(1'b0, 5 * ONE_SEC);
        nx_angle = trk_angle;
        nx_angle[3] = trk_angle[3] - 64 * ONE_RAD - 1;
        send_point(1'b0, 6 * ONE_SEC);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        directed_points();

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: load_limits($urandom_range(1 << 14, 1 << 18), $urandom_range(1 << 14, 1 << 18),
                               $urandom_range(1 << 14, 1 << 18), $urandom_range(1 << 14, 1 << 18),
                               1'b0);
                1: load_limits('0, '0, INV_TOP, INV_TOP, 1'b0);
                2: load_limits(LIMIT_TOP, LIMIT_TOP, '0, '0, 1'b0);
                // out-of-width data is masked, stray indexes ignored
                3: load_limits('1, '1, '1, '1, 1'b1);
                default: load_limits($urandom_range(0, LIMIT_TOP), $urandom_range(0, LIMIT_TOP),
                                     $urandom_range(0, INV_TOP), $urandom_range(0, INV_TOP),
                                     1'b1);
            endcase
            tx_gap_odds = (p == 0) ? 0 : $urandom_range(10, 50);

            for (int i = 0; i < PHASE_POINTS; i++) begin
                // sender pause until the pipeline has drained
                if (p == 2 && i == PHASE_POINTS / 2) begin
                    settle();
                end
                // receiver holds off while the sender keeps offering
                if (p == PHASES - 1 && i == 60) begin
                    hold_rx = 1'b1;
                    tx_calm = 1'b1;
                end
                if (p == PHASES - 1 && i == 100) begin
                    tx_calm = 1'b0;
                end
                // calm tail with no stalls on either side
                if (p == PHASES - 1 && i == PHASE_POINTS - 100) begin
                    tx_calm = 1'b1;
                    rx_calm = 1'b1;
                end
                random_point();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/tvr_pkg.sv
rtl/core/tvr_front.sv
rtl/core/tvr_queue.sv
rtl/core/tvr_back.sv
rtl/core/trajectory_velocity_retimer.sv
tb/sv/tvr_retime_checker.sv
tb/sv/trajectory_velocity_retimer_tb.sv
